// ===== hdl/gbia_pkg.sv =====
// gbia_pkg: widths, payload types, request codes, register indexes and
// fixed-point constants shared by the gyro bias/integration core.
// No dependencies.
package gbia_pkg;

	localparam int AXES     = 3;
	localparam int REQ_W    = 2;
	localparam int RAW_W    = 16;
	localparam int RATE_W   = 19;
	localparam int SUM_W    = 28;
	localparam int BIAS_W   = 20;
	localparam int ACC_W    = 48;
	localparam int ANGLE_W  = 26;
	localparam int DELTA_W  = 28;
	localparam int MAG_W    = 12;
	localparam int SPIN_W   = 13;
	localparam int SCALE_W  = 2;
	localparam int DT_W     = 16;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int PROD_SHIFT = 7;

	typedef logic signed [RAW_W-1:0]   raw_t;
	typedef logic signed [RATE_W-1:0]  rate_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [BIAS_W-1:0]  bias_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [SPIN_W-1:0]         spin_t;
	typedef logic [SCALE_W-1:0]        scale_t;
	typedef logic [DT_W-1:0]           dt_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_CAL     = 2'd0,
		REQ_MEAS    = 2'd1,
		REQ_RESTART = 2'd2
	} req_t;

	// register index is paddr[2]
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_DT    = 1'b1;

	localparam scale_t SCALE_RESET = 2'd0;
	localparam dt_t    DT_RESET    = 16'd3277;

	localparam rate_t RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam rate_t RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
	localparam sum_t  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
	localparam acc_t  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

	// one full turn, Q16
	localparam longint TURN_Q16  = longint'(360) * longint'(65536);
	// whole turns one step can cover: |rate*dt|>>7 < 6 turns
	localparam int     TURN_MULT = 5;
	localparam longint ACC_MAX_L = (longint'(1) <<< (ACC_W-1)) - longint'(1);
	localparam angle_t REM_AT_MAX = ANGLE_W'(ACC_MAX_L % TURN_Q16);
	localparam angle_t REM_AT_MIN = ANGLE_W'(-((ACC_MAX_L + longint'(1)) % TURN_Q16));

	typedef struct packed {
		logic accept;
		req_t req_in;
		logic cal_done;
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
		req_t req_s3;
	} ctrl_t;

endpackage

// ===== hdl/gbia_in_if.sv =====
// gbia_in_if: sample channel, valid/ready plus request code and raw axes.
// Depends on gbia_pkg.
interface gbia_in_if;
	logic                          valid;
	logic                          ready;
	logic [gbia_pkg::REQ_W-1:0]    req_type;
	gbia_pkg::raw_t                raw_x;
	gbia_pkg::raw_t                raw_y;
	gbia_pkg::raw_t                raw_z;

	modport source (output valid, req_type, raw_x, raw_y, raw_z, input ready);
	modport sink (input valid, req_type, raw_x, raw_y, raw_z, output ready);
endinterface

// ===== hdl/gbia_out_if.sv =====
// gbia_out_if: result channel, valid/ready plus rates, angles, spin rate and
// calibration flag. Depends on gbia_pkg.
interface gbia_out_if;
	logic             valid;
	logic             ready;
	gbia_pkg::rate_t  rate_x;
	gbia_pkg::rate_t  rate_y;
	gbia_pkg::rate_t  rate_z;
	gbia_pkg::angle_t angle_x;
	gbia_pkg::angle_t angle_y;
	gbia_pkg::angle_t angle_z;
	gbia_pkg::spin_t  spin_rate;
	logic             calibrated;

	modport source (output valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
		spin_rate, calibrated, input ready);
	modport sink (input valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
		spin_rate, calibrated, output ready);
endinterface

// ===== hdl/gbia_div.sv =====
// gbia_div: signed calibration sum divided by CAL_SAMPLES, truncated toward zero.
// Reciprocal multiply, remainder check and one-step correction.
// Depends on gbia_pkg.
module gbia_div #(
	parameter int CAL_SAMPLES = 200
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gbia_pkg::sum_t  sum,
	output logic            busy,
	output logic            done,
	output gbia_pkg::bias_t quot
);
	localparam int SW = gbia_pkg::SUM_W;
	localparam int NW = $clog2(CAL_SAMPLES + 1);
	localparam int RW = SW + 1;
	localparam int PW = SW + RW;
	localparam int QW = SW + NW;
	localparam longint RECIP = (longint'(1) <<< SW) / CAL_SAMPLES;
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
	localparam logic [QW-1:0] DIVISOR = QW'(CAL_SAMPLES);

	logic [2:0]    v_q;
	logic [SW-1:0] a_q;
	logic          neg_q;
	logic [SW-1:0] q0_q;
	logic [QW-1:0] qn_q;

	logic [PW-1:0] prod_m;
	logic [QW-1:0] prod_n;
	logic [QW-1:0] resid;
	logic [SW-1:0] qmag;
	logic [SW-1:0] qsgn;

	// q0 is the quotient or one less
	assign prod_m = PW'(a_q) * PW'(RECIP_V);
	assign prod_n = QW'(q0_q) * DIVISOR;
	assign resid  = QW'(a_q) - qn_q;
	assign qmag   = (resid >= DIVISOR) ? q0_q + SW'(1) : q0_q;
	assign qsgn   = neg_q ? (~qmag + SW'(1)) : qmag;
	assign quot   = qsgn[gbia_pkg::BIAS_W-1:0];
	assign busy   = |v_q;
	assign done   = v_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[1:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= sum[SW-1];
			a_q   <= sum[SW-1] ? (~sum + SW'(1)) : sum;
		end
		if (v_q[0]) begin
			q0_q <= prod_m[2*SW-1:SW];
		end
		if (v_q[1]) begin
			qn_q <= prod_n;
		end
	end
endmodule

// ===== hdl/gbia_lane.sv =====
// gbia_lane: one gyro axis. Scaling, calibration sum and bias, rate, rate*dt
// step, turn reduction and the saturating angle accumulator with its running
// remainder. Depends on gbia_pkg and gbia_div.
module gbia_lane #(
	parameter int CAL_SAMPLES = 200
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gbia_pkg::ctrl_t  ctrl,
	input  gbia_pkg::raw_t   raw,
	input  gbia_pkg::scale_t gyro_scale,
	input  gbia_pkg::dt_t    dt_q16,
	output logic             busy,
	output gbia_pkg::mag_t   mag_s2,
	output gbia_pkg::rate_t  rate_s3,
	output gbia_pkg::angle_t angle_next
);
	localparam int RATE_W  = gbia_pkg::RATE_W;
	localparam int SUM_W   = gbia_pkg::SUM_W;
	localparam int BIAS_W  = gbia_pkg::BIAS_W;
	localparam int ACC_W   = gbia_pkg::ACC_W;
	localparam int ANGLE_W = gbia_pkg::ANGLE_W;
	localparam int DELTA_W = gbia_pkg::DELTA_W;
	localparam int PROD_W  = RATE_W + gbia_pkg::DT_W + 1;
	localparam int SH      = gbia_pkg::PROD_SHIFT;
	localparam int W2      = ANGLE_W + 2;
	localparam logic signed [W2-1:0] T1 = W2'(gbia_pkg::TURN_Q16);
	localparam logic signed [W2-1:0] T2 = W2'(2 * gbia_pkg::TURN_Q16);

	// state
	gbia_pkg::sum_t   sum_q;
	gbia_pkg::bias_t  bias_q;
	gbia_pkg::acc_t   acc_q;
	gbia_pkg::angle_t rem_q;

	// pipeline
	gbia_pkg::rate_t  rate_s1;
	gbia_pkg::rate_t  rate_s2;
	gbia_pkg::delta_t delta_s2;
	gbia_pkg::delta_t delta_s3;
	gbia_pkg::angle_t dr_s3;

	gbia_pkg::rate_t          scaled;
	logic signed [SUM_W:0]    sum_w;
	gbia_pkg::sum_t           sum_sat;
	logic signed [BIAS_W:0]   diff;
	gbia_pkg::rate_t          rate_sat;
	logic signed [PROD_W-1:0] prod;
	logic [RATE_W-1:0]        rate_abs;
	logic [DELTA_W-1:0]       dmag;
	logic [DELTA_W-1:0]       dsub;
	logic [DELTA_W-1:0]       rmag;
	gbia_pkg::angle_t         dr_mag;
	logic signed [ACC_W:0]    acc_w;
	gbia_pkg::acc_t           acc_next;
	logic acc_hi;
	logic acc_lo;
	logic signed [W2-1:0]     xw;
	logic signed [W2-1:0]     xp1;
	logic signed [W2-1:0]     xp2;
	logic signed [W2-1:0]     xm1;
	logic signed [W2-1:0]     xm2;
	logic signed [W2-1:0]     rem_w;
	gbia_pkg::angle_t         rem_next;
	logic                     div_start;
	logic                     div_done;
	gbia_pkg::bias_t          div_quot;

	assign scaled = RATE_W'(raw) <<< gyro_scale;

	assign sum_w = (SUM_W+1)'(sum_q) + (SUM_W+1)'(scaled);
	assign sum_sat = (sum_w[SUM_W] != sum_w[SUM_W-1]) ?
		(sum_w[SUM_W] ? gbia_pkg::SUM_MIN : gbia_pkg::SUM_MAX) : sum_w[SUM_W-1:0];

	assign diff = (BIAS_W+1)'(scaled) - (BIAS_W+1)'(bias_q);
	always_comb begin
		if (diff > (BIAS_W+1)'(gbia_pkg::RATE_MAX)) begin
			rate_sat = gbia_pkg::RATE_MAX;
		end else if (diff < (BIAS_W+1)'(gbia_pkg::RATE_MIN)) begin
			rate_sat = gbia_pkg::RATE_MIN;
		end else begin
			rate_sat = diff[RATE_W-1:0];
		end
	end

	assign div_start = ctrl.accept && ctrl.cal_done;

	gbia_div #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (sum_sat),
		.busy   (busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			bias_q <= '0;
		end else begin
			if (div_done) begin
				bias_q <= div_quot;
			end else if (ctrl.accept && ctrl.req_in == gbia_pkg::REQ_RESTART) begin
				bias_q <= '0;
			end
			if (ctrl.accept) begin
				if (ctrl.req_in == gbia_pkg::REQ_RESTART || div_start) begin
					sum_q <= '0;
				end else if (ctrl.req_in == gbia_pkg::REQ_CAL) begin
					sum_q <= sum_sat;
				end
			end
		end
	end

	// s2: rate step, floor of Q23 -> Q16
	assign prod = PROD_W'(rate_s1) * PROD_W'($signed({1'b0, dt_q16}));
	assign rate_abs = rate_s1[RATE_W-1] ? (~rate_s1 + RATE_W'(1)) : rate_s1;

	// s3: strip whole turns off the step
	assign dmag = delta_s2[DELTA_W-1] ? (~delta_s2 + DELTA_W'(1)) : delta_s2;
	always_comb begin
		dsub = '0;
		for (int i = 1; i <= gbia_pkg::TURN_MULT; i++) begin
			if (dmag >= DELTA_W'(i * gbia_pkg::TURN_Q16)) begin
				dsub = DELTA_W'(i * gbia_pkg::TURN_Q16);
			end
		end
	end
	assign rmag   = dmag - dsub;
	assign dr_mag = rmag[ANGLE_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			rate_s1 <= (ctrl.req_in == gbia_pkg::REQ_MEAS) ? rate_sat : '0;
		end
		if (ctrl.ld_s2) begin
			rate_s2  <= rate_s1;
			delta_s2 <= prod[DELTA_W+SH-1:SH];
			mag_s2   <= rate_abs[RATE_W-1:SH];
		end
		if (ctrl.ld_s3) begin
			rate_s3  <= rate_s2;
			delta_s3 <= delta_s2;
			dr_s3    <= delta_s2[DELTA_W-1] ? -dr_mag : dr_mag;
		end
	end

	// accumulator and remainder, kept congruent mod one turn
	assign acc_w  = (ACC_W+1)'(acc_q) + (ACC_W+1)'(delta_s3);
	assign acc_hi = !acc_w[ACC_W] && acc_w[ACC_W-1];
	assign acc_lo = acc_w[ACC_W] && !acc_w[ACC_W-1];
	assign acc_next = acc_hi ? gbia_pkg::ACC_MAX :
		(acc_lo ? gbia_pkg::ACC_MIN : acc_w[ACC_W-1:0]);

	assign xw  = W2'(rem_q) + W2'(dr_s3);
	assign xp1 = xw + T1;
	assign xp2 = xw + T2;
	assign xm1 = xw - T1;
	assign xm2 = xw - T2;

	always_comb begin
		if (!acc_next[ACC_W-1]) begin
			if (xw[W2-1]) begin
				rem_w = xp1[W2-1] ? xp2 : xp1;
			end else begin
				rem_w = xm1[W2-1] ? xw : xm1;
			end
		end else begin
			if (!xw[W2-1] && xw != '0) begin
				rem_w = (xm1[W2-1] || xm1 == '0) ? xm1 : xm2;
			end else begin
				rem_w = (xp1[W2-1] || xp1 == '0) ? xp1 : xw;
			end
		end
	end

	assign rem_next = acc_hi ? gbia_pkg::REM_AT_MAX :
		(acc_lo ? gbia_pkg::REM_AT_MIN : rem_w[ANGLE_W-1:0]);

	always_comb begin
		unique case (ctrl.req_s3)
			gbia_pkg::REQ_RESTART: angle_next = '0;
			gbia_pkg::REQ_MEAS:    angle_next = rem_next;
			default:               angle_next = rem_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
		end else if (ctrl.ld_out) begin
			if (ctrl.req_s3 == gbia_pkg::REQ_RESTART) begin
				acc_q <= '0;
				rem_q <= '0;
			end else if (ctrl.req_s3 == gbia_pkg::REQ_MEAS) begin
				acc_q <= acc_next;
				rem_q <= rem_next;
			end
		end
	end
endmodule

// ===== hdl/gbia_merge.sv =====
// gbia_merge: combines the three lanes' whole-deg/s magnitudes into the spin
// rate and holds the previous measurement's value. Depends on gbia_pkg.
module gbia_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gbia_pkg::ctrl_t                       ctrl,
	input  gbia_pkg::mag_t [gbia_pkg::AXES-1:0]   mag,
	output gbia_pkg::spin_t                       spin
);
	localparam int SPIN_W = gbia_pkg::SPIN_W;

	gbia_pkg::spin_t spin_max;
	gbia_pkg::spin_t spin_s3;
	gbia_pkg::spin_t last_spin_q;

	always_comb begin
		spin_max = '0;
		for (int i = 0; i < gbia_pkg::AXES; i++) begin
			if (SPIN_W'(mag[i]) > spin_max) begin
				spin_max = SPIN_W'(mag[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			spin_s3 <= spin_max;
		end
	end

	assign spin = (ctrl.req_s3 == gbia_pkg::REQ_RESTART) ? '0 : last_spin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_spin_q <= '0;
		end else if (ctrl.ld_out) begin
			if (ctrl.req_s3 == gbia_pkg::REQ_RESTART) begin
				last_spin_q <= '0;
			end else if (ctrl.req_s3 == gbia_pkg::REQ_MEAS) begin
				last_spin_q <= spin_s3;
			end
		end
	end
endmodule

// ===== hdl/gyro_bias_integrate_angle_core.sv =====
// Gyro bias calibration and angle integration core. One sample transfer is
// taken per clock unless result back-pressure or a busy divider holds it off;
// each gives one result through three axis lanes (scale and bias, 19x17
// rate*dt multiply, turn reduction, accumulator) and a merging stage for
// the spin rate. The output register lets new samples enter while a result
// waits. The calibration sample that completes CAL_SAMPLES holds the input
// off while the reciprocal-multiply divider loads the bias. Registers:
// gyro_scale at byte address 0, dt_q16 at 4; write only while idle.
// Depends on gbia_pkg, gbia_in_if, gbia_out_if, gbia_lane, gbia_merge.
module gyro_bias_integrate_angle_core #(
	parameter int CAL_SAMPLES = 200
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gbia_pkg::PADDR_W-1:0]  paddr,
	input  logic [gbia_pkg::PDATA_W-1:0]  pwdata,
	output logic [gbia_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	gbia_in_if.sink                       sample,
	gbia_out_if.source                    result
);
	localparam int AXES = gbia_pkg::AXES;
	localparam int CW   = $clog2(CAL_SAMPLES + 1);

	gbia_pkg::scale_t gyro_scale_q;
	gbia_pkg::dt_t    dt_q16_q;
	logic             cfg_wr;

	logic [CW-1:0]    cnt_q;
	logic [CW:0]      cnt_inc;
	logic             bias_valid_q;

	logic v_s1, v_s2, v_s3, out_v_q;
	logic free_o, go1, go2, go3, en1, en2, en3;
	logic accept, cal_done, cal_next;
	gbia_pkg::req_t req_in, req_s1, req_s2, req_s3;
	logic cal_s1, cal_s2, cal_s3;
	logic [AXES-1:0] busy;
	gbia_pkg::ctrl_t ctrl;

	gbia_pkg::raw_t                  raw [AXES];
	gbia_pkg::mag_t [AXES-1:0]       mag_s2;
	gbia_pkg::rate_t                 rate_s3 [AXES];
	gbia_pkg::angle_t                angle_next [AXES];
	gbia_pkg::spin_t                 spin;

	gbia_pkg::rate_t  rate_q [AXES];
	gbia_pkg::angle_t angle_q [AXES];
	gbia_pkg::spin_t  spin_q;
	logic             cal_out_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_scale_q <= gbia_pkg::SCALE_RESET;
			dt_q16_q     <= gbia_pkg::DT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				gbia_pkg::REG_SCALE: gyro_scale_q <= pwdata[gbia_pkg::SCALE_W-1:0];
				gbia_pkg::REG_DT:    dt_q16_q     <= pwdata[gbia_pkg::DT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			gbia_pkg::REG_SCALE: prdata = gbia_pkg::PDATA_W'(gyro_scale_q);
			gbia_pkg::REG_DT:    prdata = gbia_pkg::PDATA_W'(dt_q16_q);
		endcase
	end

	// pipeline flow
	assign free_o = !out_v_q || result.ready;
	assign go3 = !v_s3 || free_o;
	assign en3 = v_s3 && free_o;
	assign go2 = !v_s2 || go3;
	assign en2 = v_s2 && go3;
	assign go1 = !v_s1 || go2;
	assign en1 = v_s1 && go2;

	assign sample.ready = go1 && !(|busy);
	assign accept = sample.valid && sample.ready;
	assign req_in = gbia_pkg::req_t'(sample.req_type);

	// calibration count
	assign cnt_inc  = (CW+1)'(cnt_q) + (CW+1)'(1);
	assign cal_done = (req_in == gbia_pkg::REQ_CAL) && (cnt_inc >= (CW+1)'(CAL_SAMPLES));
	assign cal_next = (req_in == gbia_pkg::REQ_RESTART) ? 1'b0 :
		(cal_done ? 1'b1 : bias_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			bias_valid_q <= 1'b0;
		end else if (accept) begin
			bias_valid_q <= cal_next;
			if (req_in == gbia_pkg::REQ_RESTART || cal_done) begin
				cnt_q <= '0;
			end else if (req_in == gbia_pkg::REQ_CAL) begin
				cnt_q <= cnt_inc[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1    <= accept || (v_s1 && !en1);
			v_s2    <= en1 || (v_s2 && !en2);
			v_s3    <= en2 || (v_s3 && !en3);
			out_v_q <= en3 || (out_v_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_in;
			cal_s1 <= cal_next;
		end
		if (en1) begin
			req_s2 <= req_s1;
			cal_s2 <= cal_s1;
		end
		if (en2) begin
			req_s3 <= req_s2;
			cal_s3 <= cal_s2;
		end
	end

	assign ctrl.accept   = accept;
	assign ctrl.req_in   = req_in;
	assign ctrl.cal_done = cal_done;
	assign ctrl.ld_s2    = en1;
	assign ctrl.ld_s3    = en2;
	assign ctrl.ld_out   = en3;
	assign ctrl.req_s3   = req_s3;

	assign raw[0] = sample.raw_x;
	assign raw[1] = sample.raw_y;
	assign raw[2] = sample.raw_z;

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		gbia_lane #(
			.CAL_SAMPLES (CAL_SAMPLES)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.raw        (raw[g]),
			.gyro_scale (gyro_scale_q),
			.dt_q16     (dt_q16_q),
			.busy       (busy[g]),
			.mag_s2     (mag_s2[g]),
			.rate_s3    (rate_s3[g]),
			.angle_next (angle_next[g])
		);
	end

	gbia_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.mag    (mag_s2),
		.spin   (spin)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < AXES; i++) begin
				rate_q[i]  <= rate_s3[i];
				angle_q[i] <= angle_next[i];
			end
			spin_q    <= spin;
			cal_out_q <= cal_s3;
		end
	end

	assign result.valid      = out_v_q;
	assign result.rate_x     = rate_q[0];
	assign result.rate_y     = rate_q[1];
	assign result.rate_z     = rate_q[2];
	assign result.angle_x    = angle_q[0];
	assign result.angle_y    = angle_q[1];
	assign result.angle_z    = angle_q[2];
	assign result.spin_rate  = spin_q;
	assign result.calibrated = cal_out_q;
endmodule

// ===== tb/gyro_bias_integrate_angle_core_check.sv =====
`timescale 1ns / 100ps
// Scoreboard for the gyro bias/integration core: follows register writes and
// sample transfers, predicts each result and compares every result transfer.
// Depends on gbia_pkg, gbia_in_if and gbia_out_if.
module gyro_bias_integrate_angle_core_check #(
	parameter int CAL_SAMPLES = 200
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gbia_pkg::PADDR_W-1:0] paddr,
	input  logic [gbia_pkg::PDATA_W-1:0] pwdata,
	input  logic                         pready,
	gbia_in_if                           sample,
	gbia_out_if                          result,
	output int                           pending,
	output int                           errors
);

	typedef struct packed {
		gbia_pkg::rate_t  rx;
		gbia_pkg::rate_t  ry;
		gbia_pkg::rate_t  rz;
		gbia_pkg::angle_t ax;
		gbia_pkg::angle_t ay;
		gbia_pkg::angle_t az;
		gbia_pkg::spin_t  spin;
		logic             cal;
	} reading_t;

	gbia_pkg::scale_t scale_q = gbia_pkg::SCALE_RESET;
	gbia_pkg::dt_t    dt_q = gbia_pkg::DT_RESET;
	gbia_pkg::bias_t  bias_q[gbia_pkg::AXES];
	gbia_pkg::sum_t   cal_sum[gbia_pkg::AXES];
	gbia_pkg::acc_t   acc_q[gbia_pkg::AXES];
	int               cal_cnt;
	gbia_pkg::spin_t  last_spin;
	logic             bias_ok;
	reading_t         expected_readings[$];
	int               err_cnt = 0;

	assign errors = err_cnt;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic clear_state();
		for (int i = 0; i < gbia_pkg::AXES; i++) begin
			bias_q[i] = '0;
			cal_sum[i] = '0;
			acc_q[i] = '0;
		end
		cal_cnt = 0;
		last_spin = '0;
		bias_ok = 1'b0;
	endtask

	task automatic integrate_sample(input logic [gbia_pkg::REQ_W-1:0] req,
		input gbia_pkg::raw_t rx, ry, rz, output reading_t r);
		gbia_pkg::raw_t   raw[gbia_pkg::AXES];
		longint           scaled[gbia_pkg::AXES];
		longint           rate[gbia_pkg::AXES];
		longint           mag;
		gbia_pkg::spin_t  spin_out;
		gbia_pkg::spin_t  spin_max;
		gbia_pkg::rate_t  rt[gbia_pkg::AXES];
		gbia_pkg::angle_t an[gbia_pkg::AXES];
		raw[0] = rx;
		raw[1] = ry;
		raw[2] = rz;
		for (int i = 0; i < gbia_pkg::AXES; i++) begin
			scaled[i] = longint'(raw[i]) <<< scale_q;
			rate[i] = 0;
		end
		if (req == gbia_pkg::REQ_RESTART)
			clear_state();
		spin_out = last_spin;
		spin_max = '0;
		case (req)
			gbia_pkg::REQ_CAL: begin
				for (int i = 0; i < gbia_pkg::AXES; i++)
					cal_sum[i] = gbia_pkg::sum_t'(clamp(longint'(cal_sum[i]) + scaled[i],
						gbia_pkg::SUM_MIN, gbia_pkg::SUM_MAX));
				cal_cnt++;
				if (cal_cnt >= CAL_SAMPLES) begin
					for (int i = 0; i < gbia_pkg::AXES; i++) begin
						bias_q[i] = gbia_pkg::bias_t'(longint'(cal_sum[i]) / CAL_SAMPLES);
						cal_sum[i] = '0;
					end
					cal_cnt = 0;
					bias_ok = 1'b1;
				end
			end
			gbia_pkg::REQ_MEAS: begin
				for (int i = 0; i < gbia_pkg::AXES; i++) begin
					rate[i] = clamp(scaled[i] - longint'(bias_q[i]),
						gbia_pkg::RATE_MIN, gbia_pkg::RATE_MAX);
					// Q7 * Q16 product back to Q16, floor
					acc_q[i] = gbia_pkg::acc_t'(clamp(longint'(acc_q[i]) +
						((rate[i] * longint'(dt_q)) >>> gbia_pkg::PROD_SHIFT),
						gbia_pkg::ACC_MIN, gbia_pkg::ACC_MAX));
					mag = (rate[i] < 0) ? -rate[i] : rate[i];
					if ((mag >>> gbia_pkg::PROD_SHIFT) > longint'(spin_max))
						spin_max = gbia_pkg::spin_t'(mag >>> gbia_pkg::PROD_SHIFT);
				end
				last_spin = spin_max;
			end
			default: ;
		endcase
		for (int i = 0; i < gbia_pkg::AXES; i++) begin
			rt[i] = gbia_pkg::rate_t'(rate[i]);
			an[i] = gbia_pkg::angle_t'(longint'(acc_q[i]) % gbia_pkg::TURN_Q16);
		end
		r.rx = rt[0];
		r.ry = rt[1];
		r.rz = rt[2];
		r.ax = an[0];
		r.ay = an[1];
		r.az = an[2];
		r.spin = spin_out;
		r.cal = bias_ok;
	endtask

	task automatic compare_field(input string field, input longint want, input longint got);
		if (want != got) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			scale_q = gbia_pkg::SCALE_RESET;
			dt_q = gbia_pkg::DT_RESET;
			clear_state();
			expected_readings.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == gbia_pkg::REG_DT)
					dt_q = pwdata[gbia_pkg::DT_W-1:0];
				else
					scale_q = pwdata[gbia_pkg::SCALE_W-1:0];
			end
			if (result.valid && result.ready) begin
				if (expected_readings.size() == 0) begin
					err_cnt++;
					$display("%0t: result transfer with no expected result, expected none, got one",
						$time);
				end else begin
					want = expected_readings.pop_front();
					compare_field("rate_x", want.rx, result.rate_x);
					compare_field("rate_y", want.ry, result.rate_y);
					compare_field("rate_z", want.rz, result.rate_z);
					compare_field("angle_x", want.ax, result.angle_x);
					compare_field("angle_y", want.ay, result.angle_y);
					compare_field("angle_z", want.az, result.angle_z);
					compare_field("spin_rate", want.spin, result.spin_rate);
					compare_field("calibrated", want.cal, result.calibrated);
				end
			end
			if (sample.valid && sample.ready) begin
				integrate_sample(sample.req_type, sample.raw_x, sample.raw_y, sample.raw_z, want);
				expected_readings.push_back(want);
			end
			pending <= expected_readings.size();
		end
	end

endmodule

// ===== tb/gyro_bias_integrate_angle_core_test.sv =====
`timescale 1ns / 100ps
// Top of the gyro bias/integration testbench: clock, reset, register writes,
// sample stimulus and result back-pressure around the core and its scoreboard.
// Depends on gbia_pkg, gbia_in_if, gbia_out_if, the core and the scoreboard.
module gyro_bias_integrate_angle_core_test;

	localparam int CAL_N = 200;
	localparam int LIMIT = 400000;
	localparam logic [gbia_pkg::PADDR_W-1:0] ADDR_SCALE = {gbia_pkg::REG_SCALE, 2'b00};
	localparam logic [gbia_pkg::PADDR_W-1:0] ADDR_DT = {gbia_pkg::REG_DT, 2'b00};
	localparam logic [gbia_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
	localparam gbia_pkg::raw_t RAW_HI = 16'sh7fff;
	localparam gbia_pkg::raw_t RAW_LO = 16'sh8000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [gbia_pkg::PADDR_W-1:0] paddr = '0;
	logic [gbia_pkg::PDATA_W-1:0] pwdata = '0;
	logic [gbia_pkg::PDATA_W-1:0] prdata;
	logic                         pready;
	int                           pending;
	int                           errors;
	int                           cycles = 0;
	int                           burst_left = 0;
	logic                         hold_req = 1'b0;

	gbia_in_if  sample();
	gbia_out_if result();

	gyro_bias_integrate_angle_core #(.CAL_SAMPLES(CAL_N)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample(sample),
		.result(result)
	);

	gyro_bias_integrate_angle_core_check #(.CAL_SAMPLES(CAL_N)) angle_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.sample(sample),
		.result(result),
		.pending(pending),
		.errors(errors)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("gyro_bias_integrate_angle_core_test NOT OK");
			$finish;
		end
	end

	function automatic gbia_pkg::raw_t pick_raw();
		case ($urandom_range(0, 9))
			0: return RAW_HI;
			1: return RAW_LO;
			2, 3: return gbia_pkg::raw_t'(int'($urandom_range(0, 400)) - 200);
			default: return gbia_pkg::raw_t'($urandom);
		endcase
	endfunction

	function automatic gbia_pkg::raw_t raw_near(gbia_pkg::raw_t base, int spread);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > int'(RAW_HI))
			v = int'(RAW_HI);
		if (v < int'(RAW_LO))
			v = int'(RAW_LO);
		return gbia_pkg::raw_t'(v);
	endfunction

	task automatic send(input logic [gbia_pkg::REQ_W-1:0] req, input gbia_pkg::raw_t x, y, z);
		int gap;
		@(negedge clk);
		sample.valid <= 1'b1;
		sample.req_type <= req;
		sample.raw_x <= x;
		sample.raw_y <= y;
		sample.raw_z <= z;
		do @(posedge clk); while (!sample.ready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				sample.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic quiesce();
		@(negedge clk);
		sample.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		// covers pipeline depth and the bias load hold-off
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [gbia_pkg::PADDR_W-1:0] addr,
		input logic [gbia_pkg::PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input gbia_pkg::scale_t scale, input gbia_pkg::dt_t dt);
		quiesce();
		apb_write(ADDR_SCALE, gbia_pkg::PDATA_W'(scale));
		apb_write(ADDR_DT, gbia_pkg::PDATA_W'(dt));
	endtask

	task automatic calibrate();
		gbia_pkg::raw_t base[gbia_pkg::AXES];
		gbia_pkg::raw_t v[gbia_pkg::AXES];
		int   spread;
		int   n;
		int   r;
		int   restarts;
		for (int a = 0; a < gbia_pkg::AXES; a++)
			case ($urandom_range(0, 3))
				0: base[a] = RAW_HI;
				1: base[a] = RAW_LO;
				default: base[a] = gbia_pkg::raw_t'($urandom);
			endcase
		spread = $urandom_range(0, 300);
		send(gbia_pkg::REQ_RESTART, pick_raw(), pick_raw(), pick_raw());
		n = 0;
		restarts = 0;
		while (n < CAL_N) begin
			r = $urandom_range(0, 199);
			if (r < 6) begin
				send(gbia_pkg::REQ_MEAS, pick_raw(), pick_raw(), pick_raw());
			end else if (r == 6 && restarts == 0) begin
				send(gbia_pkg::REQ_RESTART, pick_raw(), pick_raw(), pick_raw());
				restarts++;
				n = 0;
			end else begin
				for (int a = 0; a < gbia_pkg::AXES; a++)
					v[a] = raw_near(base[a], spread);
				send(gbia_pkg::REQ_CAL, v[0], v[1], v[2]);
				n++;
			end
		end
	endtask

	task automatic mixed(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				send(gbia_pkg::REQ_MEAS, pick_raw(), pick_raw(), pick_raw());
			else if (r < 94)
				send(gbia_pkg::REQ_CAL, pick_raw(), pick_raw(), pick_raw());
			else if (r < 97)
				send(REQ_SPARE, pick_raw(), pick_raw(), pick_raw());
			else
				send(gbia_pkg::REQ_RESTART, pick_raw(), pick_raw(), pick_raw());
		end
	endtask

	initial begin
		int mode_left;
		int stall_pct;
		logic held;
		mode_left = 0;
		stall_pct = 0;
		held = 1'b0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				result.ready <= 1'b0;
				repeat (120) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(16, 96);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			mode_left--;
			result.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		sample.valid = 1'b0;
		sample.req_type = gbia_pkg::REQ_CAL;
		sample.raw_x = '0;
		sample.raw_y = '0;
		sample.raw_z = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_config(2'd3, 16'hffff);
		send(gbia_pkg::REQ_MEAS, 16'sd0, 16'sd0, 16'sd0);
		send(gbia_pkg::REQ_MEAS, RAW_HI, RAW_LO, 16'sd1);
		send(gbia_pkg::REQ_MEAS, RAW_LO, RAW_HI, -16'sd1);
		send(REQ_SPARE, RAW_HI, RAW_HI, RAW_LO);
		send(gbia_pkg::REQ_CAL, RAW_HI, RAW_LO, 16'sd0);
		send(gbia_pkg::REQ_CAL, RAW_LO, RAW_HI, 16'sd100);
		send(gbia_pkg::REQ_MEAS, -16'sd1, 16'sd0, RAW_HI);
		send(gbia_pkg::REQ_RESTART, RAW_LO, RAW_LO, RAW_HI);
		send(gbia_pkg::REQ_MEAS, RAW_HI, RAW_HI, RAW_HI);
		send(gbia_pkg::REQ_MEAS, RAW_LO, RAW_LO, RAW_LO);
		send(REQ_SPARE, 16'sd0, 16'sd0, 16'sd0);
		send(gbia_pkg::REQ_CAL, 16'sd5, -16'sd5, 16'sd255);
		send(gbia_pkg::REQ_MEAS, 16'sd12345, -16'sd12345, 16'sd128);
		send(gbia_pkg::REQ_RESTART, 16'sd0, 16'sd0, 16'sd0);
		send(gbia_pkg::REQ_MEAS, gbia_pkg::raw_t'(16'h5555), gbia_pkg::raw_t'(16'haaaa),
			gbia_pkg::raw_t'(16'h00ff));

		set_config(2'd0, 16'd1);
		mixed(80);
		set_config(2'd3, 16'hffff);
		calibrate();
		mixed(80);
		set_config(2'd1, gbia_pkg::dt_t'($urandom_range(1, 65535)));
		hold_req <= 1'b1;
		mixed(80);
		set_config(2'd2, gbia_pkg::dt_t'($urandom_range(1, 65535)));
		calibrate();
		mixed(80);
		set_config(gbia_pkg::scale_t'($urandom_range(0, 3)),
			gbia_pkg::dt_t'($urandom_range(1, 65535)));
		mixed(80);
		quiesce();

		if (errors == 0)
			$display("gyro_bias_integrate_angle_core_test OK");
		else
			$display("gyro_bias_integrate_angle_core_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/gbia_pkg.sv
hdl/gbia_in_if.sv
hdl/gbia_out_if.sv
hdl/gbia_div.sv
hdl/gbia_lane.sv
hdl/gbia_merge.sv
hdl/gyro_bias_integrate_angle_core.sv
tb/gyro_bias_integrate_angle_core_check.sv
tb/gyro_bias_integrate_angle_core_test.sv
